// ===== src/asc_pkg.sv =====
`timescale 1ns / 1ps

package asc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_BYPASS      = 3'd0;
    localparam logic [2:0] REG_COLOR_TYPE  = 3'd1;
    localparam logic [2:0] REG_DRIVE       = 3'd2;
    localparam logic [2:0] REG_TONE        = 3'd3;
    localparam logic [2:0] REG_WET_MIX     = 3'd4;
    localparam logic [2:0] REG_OUTPUT_GAIN = 3'd5;

    // Curve codes
    localparam logic [1:0] COLOR_TAPE  = 2'd0;
    localparam logic [1:0] COLOR_TUBE  = 2'd1;
    localparam logic [1:0] COLOR_XFMR  = 2'd2;
    localparam logic [1:0] COLOR_CLIP  = 2'd3;

    // Fixed-point constants
    localparam logic [15:0] UNITY_Q15   = 16'd32768;
    localparam logic [15:0] TONE_K      = 16'd9830;
    localparam logic [15:0] TAPE_K      = 16'd29491;
    localparam logic [15:0] DC_K        = 16'd5243;
    localparam logic [25:0] XF_TH_LO    = 26'd2768241;
    localparam logic [25:0] XF_TH_HI    = 26'd5536481;
    localparam logic [25:0] ONE_Q23     = 26'd8388608;
    localparam logic [25:0] FOUR_Q23    = 26'd33554432;
    // ceil(2^27 / 3): exact floor division by three for numerators below 2^25
    localparam logic [25:0] THIRD_Q27   = 26'd44739243;

    // Sequencer states
    typedef enum logic [18:0] {
        ST_IDLE  = 19'h00001,
        ST_DRV   = 19'h00002,
        ST_ABS   = 19'h00004,
        ST_CRV   = 19'h00008,
        ST_TAPE1 = 19'h00010,
        ST_TAPE2 = 19'h00020,
        ST_TAPE3 = 19'h00040,
        ST_TUBE1 = 19'h00080,
        ST_XF1   = 19'h00100,
        ST_DIV   = 19'h00200,
        ST_TONE  = 19'h00400,
        ST_DC1   = 19'h00800,
        ST_DC2   = 19'h01000,
        ST_DC3   = 19'h02000,
        ST_MIX1  = 19'h04000,
        ST_MIX2  = 19'h08000,
        ST_MIX3  = 19'h10000,
        ST_FIN   = 19'h20000,
        ST_XF2   = 19'h40000
    } state_t;

    // tanh(i/8) in Q1.15
    function automatic logic [15:0] tanh_tab(input logic [5:0] i);
        logic [15:0] v;
        case (i)
            6'd0:  v = 16'd0;     6'd1:  v = 16'd4075;  6'd2:  v = 16'd8025;
            6'd3:  v = 16'd11743; 6'd4:  v = 16'd15143; 6'd5:  v = 16'd18173;
            6'd6:  v = 16'd20813; 6'd7:  v = 16'd23066; 6'd8:  v = 16'd24956;
            6'd9:  v = 16'd26519; 6'd10: v = 16'd27797; 6'd11: v = 16'd28830;
            6'd12: v = 16'd29660; 6'd13: v = 16'd30322; 6'd14: v = 16'd30847;
            6'd15: v = 16'd31262; 6'd16: v = 16'd31589; 6'd17: v = 16'd31846;
            6'd18: v = 16'd32048; 6'd19: v = 16'd32206; 6'd20: v = 16'd32329;
            6'd21: v = 16'd32426; 6'd22: v = 16'd32501; 6'd23: v = 16'd32560;
            6'd24: v = 16'd32606; 6'd25: v = 16'd32642; 6'd26: v = 16'd32670;
            6'd27: v = 16'd32691; 6'd28: v = 16'd32708; 6'd29: v = 16'd32721;
            6'd30: v = 16'd32732; 6'd31: v = 16'd32740; 6'd32: v = 16'd32746;
            default: v = 16'd32746;
        endcase
        return v;
    endfunction

endpackage

// ===== src/audio_saturation_color_stage.sv =====
`timescale 1ns / 1ps
// An accepted item walks the sequencer states one at a time. A bypassed item goes straight
// to the output state; tape, tube and the transformer middle band add curve states, and
// tube also runs the one-bit-per-cycle restoring divider. The block takes no new item until
// the last has left the output state, as the shared 35x33 multiplier and the divider serve
// one item at a time; a finished item waits while the output register is full.
// Reset (aresetn low, synchronous): sequencer idle, output empty, registers to defaults,
// DC blocker state of every channel cleared to zero.

module audio_saturation_color_stage #(
    parameter int CHANNELS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_channel_index,
    input  logic signed [23:0] s_audio_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_channel_out,
    output logic signed [23:0] m_audio_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    logic        bypass_reg;
    logic [1:0]  color_type_reg;
    logic [15:0] drive_reg, tone_reg, wet_reg, ogain_reg;

    asc_pkg::state_t state_reg, state_next;

    logic               ch_reg;
    logic signed [23:0] dry_reg;
    logic               x_neg_reg;
    logic [25:0]        a_reg;
    logic [31:0]        gain_reg;
    logic [24:0]        t_reg;
    logic [24:0]        ymag_reg;
    logic [29:0]        den_reg;
    logic [30:0]        rem_reg;
    logic [24:0]        shift_reg;
    logic [4:0]         cnt_reg;
    logic signed [31:0] s_reg;
    logic signed [27:0] o_reg;
    logic signed [34:0] diff_reg;
    logic signed [32:0] g_reg;
    logic signed [49:0] acc_reg;
    logic signed [23:0] res_reg;
    logic signed [67:0] prod_reg;
    logic signed [31:0] dc_reg [CHANNELS];

    logic               m_valid_reg, m_channel_out_reg;
    logic signed [23:0] m_audio_out_reg;

    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] prod_next;

    logic [15:0]        drv_eff, m_eff;
    logic [16:0]        dry_frac;
    logic [17:0]        drive_f;
    logic [4:0]         tidx;
    logic signed [16:0] tdiff;
    logic signed [67:0] x_full;
    logic signed [26:0] x_val;
    logic signed [25:0] ys;
    logic [24:0]        u_val;
    logic [24:0]        xf_num;
    logic [27:0]        a3;
    logic signed [67:0] w_full;
    logic signed [25:0] w_val;
    logic signed [31:0] s_cur;
    logic               have_state;
    logic [CH_W-1:0]    ch_idx;
    logic signed [67:0] corr_full;
    logic signed [33:0] ns;
    logic signed [49:0] mix_sum;
    logic signed [34:0] r_val;
    logic [30:0]        trial;
    logic               accept, out_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == asc_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == asc_pkg::ST_FIN) && (!m_valid_reg || m_ready);
    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_out_reg;
    assign m_audio_out   = m_audio_out_reg;

    // Clamp drive and mix to 1.0
    assign drv_eff  = (drive_reg > asc_pkg::UNITY_Q15) ? asc_pkg::UNITY_Q15 : drive_reg;
    assign m_eff    = (wet_reg > asc_pkg::UNITY_Q15) ? asc_pkg::UNITY_Q15 : wet_reg;
    assign dry_frac = 17'({1'b0, asc_pkg::UNITY_Q15}) - 17'(m_eff);
    assign drive_f  = 18'(asc_pkg::UNITY_Q15) + (18'({1'b0, color_type_reg}) + 18'd3) * 18'(drv_eff);

    // Datapath taps
    assign tidx   = a_reg[24:20];
    assign tdiff  = $signed({1'b0, asc_pkg::tanh_tab({1'b0, tidx} + 6'd1)})
                  - $signed({1'b0, asc_pkg::tanh_tab({1'b0, tidx})});
    assign x_full = prod_reg >>> 15;
    assign x_val  = x_full[26:0];
    assign ys     = x_neg_reg ? -$signed({1'b0, ymag_reg}) : $signed({1'b0, ymag_reg});
    assign a3     = 28'(a_reg) * 28'd3;
    assign u_val  = 25'(28'd16777216 - a3);
    assign xf_num = 25'd25165824 - prod_reg[47:23];
    assign w_full = prod_reg >>> 30;
    assign w_val  = w_full[25:0];
    assign ch_idx = CH_W'(ch_reg);
    assign have_state = (32'(ch_reg) < CHANNELS);
    assign s_cur  = have_state ? dc_reg[ch_idx] : 32'sd0;
    assign corr_full = prod_reg >>> 20;
    assign ns     = 34'(s_reg) + 34'($signed(corr_full[27:0]));
    assign mix_sum = acc_reg + prod_reg[49:0];
    assign r_val  = 35'(mix_sum >>> 15);
    assign trial  = {rem_reg[29:0], shift_reg[24]};

    // Select the operands of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            asc_pkg::ST_DRV: begin
                mul_a = 35'(dry_reg);
                mul_b = 33'($signed({1'b0, drive_f}));
            end
            asc_pkg::ST_ABS: begin
                mul_a = 35'($signed(tone_reg));
                mul_b = 33'($signed({1'b0, asc_pkg::TONE_K}));
            end
            asc_pkg::ST_CRV: begin
                case (color_type_reg)
                    asc_pkg::COLOR_TAPE: begin
                        mul_a = 35'(tdiff);
                        mul_b = 33'($signed({1'b0, a_reg[19:0]}));
                    end
                    asc_pkg::COLOR_TUBE: begin
                        mul_a = 35'($signed({1'b0, a_reg}));
                        mul_b = 33'($signed({1'b0, a_reg}));
                    end
                    asc_pkg::COLOR_XFMR: begin
                        mul_a = 35'($signed({1'b0, u_val}));
                        mul_b = 33'($signed({1'b0, u_val}));
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            asc_pkg::ST_TAPE2: begin
                mul_a = 35'($signed({1'b0, t_reg}));
                mul_b = 33'($signed({1'b0, asc_pkg::TAPE_K}));
            end
            // Divide the transformer numerator by three through the reciprocal
            asc_pkg::ST_XF1: begin
                mul_a = 35'($signed({1'b0, xf_num}));
                mul_b = 33'($signed({1'b0, asc_pkg::THIRD_Q27}));
            end
            asc_pkg::ST_TONE: begin
                mul_a = 35'(ys);
                mul_b = 33'($signed({1'b0, gain_reg}));
            end
            asc_pkg::ST_DC2: begin
                mul_a = diff_reg;
                mul_b = 33'($signed({1'b0, asc_pkg::DC_K}));
            end
            asc_pkg::ST_DC3: begin
                mul_a = 35'(o_reg);
                mul_b = 33'($signed({1'b0, ogain_reg}));
            end
            asc_pkg::ST_MIX1: begin
                mul_a = 35'(dry_reg);
                mul_b = 33'($signed({1'b0, dry_frac}));
            end
            asc_pkg::ST_MIX2: begin
                mul_a = 35'(g_reg);
                mul_b = 33'($signed({1'b0, m_eff}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asc_pkg::ST_IDLE:  if (accept) begin
                state_next = bypass_reg ? asc_pkg::ST_FIN : asc_pkg::ST_DRV;
            end
            asc_pkg::ST_DRV:   state_next = asc_pkg::ST_ABS;
            asc_pkg::ST_ABS:   state_next = asc_pkg::ST_CRV;
            asc_pkg::ST_CRV: begin
                case (color_type_reg)
                    asc_pkg::COLOR_TAPE: state_next = (a_reg >= asc_pkg::FOUR_Q23)
                                                      ? asc_pkg::ST_TAPE2 : asc_pkg::ST_TAPE1;
                    asc_pkg::COLOR_TUBE: state_next = asc_pkg::ST_TUBE1;
                    asc_pkg::COLOR_XFMR: state_next = (a_reg >= asc_pkg::XF_TH_LO &&
                                                       a_reg < asc_pkg::XF_TH_HI)
                                                      ? asc_pkg::ST_XF1 : asc_pkg::ST_TONE;
                    default:             state_next = asc_pkg::ST_TONE;
                endcase
            end
            asc_pkg::ST_TAPE1: state_next = asc_pkg::ST_TAPE2;
            asc_pkg::ST_TAPE2: state_next = asc_pkg::ST_TAPE3;
            asc_pkg::ST_TAPE3: state_next = asc_pkg::ST_TONE;
            asc_pkg::ST_TUBE1: state_next = asc_pkg::ST_DIV;
            asc_pkg::ST_XF1:   state_next = asc_pkg::ST_XF2;
            asc_pkg::ST_XF2:   state_next = asc_pkg::ST_TONE;
            asc_pkg::ST_DIV:   if (cnt_reg == 5'd25) begin
                state_next = asc_pkg::ST_TONE;
            end
            asc_pkg::ST_TONE:  state_next = asc_pkg::ST_DC1;
            asc_pkg::ST_DC1:   state_next = asc_pkg::ST_DC2;
            asc_pkg::ST_DC2:   state_next = asc_pkg::ST_DC3;
            asc_pkg::ST_DC3:   state_next = asc_pkg::ST_MIX1;
            asc_pkg::ST_MIX1:  state_next = asc_pkg::ST_MIX2;
            asc_pkg::ST_MIX2:  state_next = asc_pkg::ST_MIX3;
            asc_pkg::ST_MIX3:  state_next = asc_pkg::ST_FIN;
            asc_pkg::ST_FIN:   if (out_load) begin
                state_next = asc_pkg::ST_IDLE;
            end
            default:           state_next = asc_pkg::ST_IDLE;
        endcase
    end

    // Control state, configuration and DC blocker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= asc_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            bypass_reg     <= 1'b0;
            color_type_reg <= asc_pkg::COLOR_TAPE;
            drive_reg      <= 16'd0;
            tone_reg       <= 16'd0;
            wet_reg        <= 16'd32768;
            ogain_reg      <= 16'd4096;
            for (int i = 0; i < CHANNELS; i++) begin
                dc_reg[i] <= 32'sd0;
            end
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    asc_pkg::REG_BYPASS:      bypass_reg     <= cfg_data[0];
                    asc_pkg::REG_COLOR_TYPE:  color_type_reg <= cfg_data[1:0];
                    asc_pkg::REG_DRIVE:       drive_reg      <= cfg_data;
                    asc_pkg::REG_TONE:        tone_reg       <= cfg_data;
                    asc_pkg::REG_WET_MIX:     wet_reg        <= cfg_data;
                    asc_pkg::REG_OUTPUT_GAIN: ogain_reg      <= cfg_data;
                    default: ;
                endcase
            end
            // Write back the clamped DC average
            if (state_reg == asc_pkg::ST_DC3 && have_state) begin
                if (ns > 34'sd2147483647) begin
                    dc_reg[ch_idx] <= 32'sh7FFFFFFF;
                end else if (ns < -34'sd2147483648) begin
                    dc_reg[ch_idx] <= 32'sh80000000;
                end else begin
                    dc_reg[ch_idx] <= ns[31:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        case (state_reg)
            asc_pkg::ST_IDLE: begin
                ch_reg  <= s_channel_index;
                dry_reg <= s_audio_in;
                res_reg <= s_audio_in;
            end
            asc_pkg::ST_ABS: begin
                x_neg_reg <= x_val[26];
                a_reg     <= x_val[26] ? 26'(-x_val) : x_val[25:0];
            end
            asc_pkg::ST_CRV: begin
                gain_reg <= 32'd1073741824 + 32'(prod_reg[31:0]);
                case (color_type_reg)
                    asc_pkg::COLOR_TAPE: t_reg <= 25'(asc_pkg::tanh_tab(6'd32)) << 8;
                    asc_pkg::COLOR_XFMR: begin
                        if (a_reg < asc_pkg::XF_TH_LO) begin
                            ymag_reg <= 25'({a_reg, 1'b0});
                        end else begin
                            ymag_reg <= 25'(asc_pkg::ONE_Q23);
                        end
                    end
                    asc_pkg::COLOR_CLIP: ymag_reg <= (a_reg < asc_pkg::ONE_Q23)
                                                     ? a_reg[24:0] : 25'(asc_pkg::ONE_Q23);
                    default: ;
                endcase
            end
            asc_pkg::ST_TAPE1: begin
                t_reg <= (25'(asc_pkg::tanh_tab({1'b0, tidx})) << 8) + 25'(prod_reg[32:12]);
            end
            asc_pkg::ST_TAPE3: ymag_reg <= prod_reg[39:15];
            asc_pkg::ST_TUBE1: begin
                den_reg   <= 30'(asc_pkg::ONE_Q23) + 30'(prod_reg[51:23]);
                rem_reg   <= 31'(a3[27:3]);
                shift_reg <= {a3[2:0], 22'd0};
                cnt_reg   <= 5'd0;
            end
            // Take the quotient by three from the reciprocal product
            asc_pkg::ST_XF2: ymag_reg <= prod_reg[51:27];
            // Advance the restoring divider one quotient bit, or store the quotient once complete
            asc_pkg::ST_DIV: begin
                if (cnt_reg == 5'd25) begin
                    ymag_reg <= shift_reg;
                end else begin
                    if (trial >= 31'(den_reg)) begin
                        rem_reg   <= trial - 31'(den_reg);
                        shift_reg <= {shift_reg[23:0], 1'b1};
                    end else begin
                        rem_reg   <= trial;
                        shift_reg <= {shift_reg[23:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
            end
            asc_pkg::ST_DC1: begin
                s_reg    <= s_cur;
                o_reg    <= 28'(w_val) - 28'(s_cur >>> 7);
                diff_reg <= (35'(w_val) <<< 7) - 35'(s_cur);
            end
            asc_pkg::ST_MIX1: begin
                g_reg <= 33'(prod_reg >>> 12);
            end
            asc_pkg::ST_MIX2: acc_reg <= prod_reg[49:0];
            // Saturate the mixed item to 24 bits
            asc_pkg::ST_MIX3: begin
                if (r_val > 35'sd8388607) begin
                    res_reg <= 24'sh7FFFFF;
                end else if (r_val < -35'sd8388608) begin
                    res_reg <= 24'sh800000;
                end else begin
                    res_reg <= r_val[23:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_channel_out_reg <= ch_reg;
            m_audio_out_reg   <= res_reg;
        end
    end

    // Assertions
    a_bypass_path: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && bypass_reg |=> state_reg == asc_pkg::ST_FIN)
        else $error("bypassed item did not go straight to output");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == asc_pkg::ST_DIV |-> rem_reg < 31'(den_reg))
        else $error("divider remainder not below divisor");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == asc_pkg::ST_FIN && m_valid_reg && !m_ready |=>
        state_reg == asc_pkg::ST_FIN)
        else $error("finished item overwrote a waiting result");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == asc_pkg::ST_CRV |-> a_reg <= 26'd58720256)
        else $error("driven magnitude out of range");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic               ch;
        logic signed [23:0] audio;
    } sample_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_channel_index = 1'b0;
    logic signed [23:0] s_audio_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_channel_out;
    logic signed [23:0] m_audio_out;

    audio_saturation_color_stage uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_channel_index(s_channel_index), .s_audio_in(s_audio_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_channel_out(m_channel_out), .m_audio_out(m_audio_out)
    );

    // Shadow register file and DC blocker state
    logic        sh_bypass;
    logic [1:0]  sh_color;
    logic [15:0] sh_drive;
    logic [15:0] sh_tone;
    logic [15:0] sh_wet;
    logic [15:0] sh_gain;
    longint      dc_avg [2];

    sample_t pending_items [$];
    sample_t expected_samples [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      samples_out = 0;
    int      holdoff_left = 0;
    bit      holdoff_done = 0;
    bit      quiet;

    longint tanh_q15 [33] = '{
        0, 4075, 8025, 11743, 15143, 18173, 20813, 23066,
        24956, 26519, 27797, 28830, 29660, 30322, 30847, 31262,
        31589, 31846, 32048, 32206, 32329, 32426, 32501, 32560,
        32606, 32642, 32670, 32691, 32708, 32721, 32732, 32740,
        32746
    };

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stretch with no idling on either side
    assign quiet = (cycle_count >= 30000) && (cycle_count < 40000);

    // Saturation curve on a magnitude
    function automatic longint shape_mag(logic [1:0] color, longint a);
        longint t, idx, fr, u;
        case (color)
            asc_pkg::COLOR_TAPE: begin
                if (a >= (longint'(4) << 23)) begin
                    t = tanh_q15[32] * 256;
                end else begin
                    idx = a >>> 20;
                    fr  = a & 64'hFFFFF;
                    t = tanh_q15[idx] * 256 + (((tanh_q15[idx + 1] - tanh_q15[idx]) * fr) >>> 12);
                end
                return (t * 29491) >>> 15;
            end
            asc_pkg::COLOR_TUBE:
                return (3 * a * (longint'(1) << 22)) / ((longint'(1) << 23) + ((a * a) >>> 23));
            asc_pkg::COLOR_XFMR: begin
                if (a < 2768241) return 2 * a;
                if (a < 5536481) begin
                    u = (longint'(1) << 24) - 3 * a;
                    return (3 * (longint'(1) << 23) - ((u * u) >>> 23)) / 3;
                end
                return longint'(1) << 23;
            end
            default:
                return (a < (longint'(1) << 23)) ? a : (longint'(1) << 23);
        endcase
    endfunction

    // Work out the processed sample and advance the channel's DC state
    function automatic sample_t process_sample(sample_t it);
        sample_t r;
        longint dry, drv, k, x, a, y, w, s, o, ns, g, m, mix;
        r.ch = it.ch;
        dry = longint'(it.audio);
        if (sh_bypass) begin
            r.audio = it.audio;
            return r;
        end
        drv = (sh_drive > 16'd32768) ? 32768 : longint'(sh_drive);
        case (sh_color)
            asc_pkg::COLOR_TAPE: k = 3;
            asc_pkg::COLOR_TUBE: k = 4;
            asc_pkg::COLOR_XFMR: k = 5;
            default:             k = 6;
        endcase
        x = (dry * (32768 + k * drv)) >>> 15;
        a = (x < 0) ? -x : x;
        y = shape_mag(sh_color, a);
        if (x < 0) y = -y;
        w = (y * ((longint'(1) << 30) + longint'($signed(sh_tone)) * 9830)) >>> 30;
        s = dc_avg[it.ch];
        o = w - (s >>> 7);
        ns = s + (((w * 128 - s) * 5243) >>> 20);
        if (ns > 64'sd2147483647) ns = 64'sd2147483647;
        if (ns < -64'sd2147483648) ns = -64'sd2147483648;
        dc_avg[it.ch] = ns;
        g = (o * longint'(sh_gain)) >>> 12;
        m = (sh_wet > 16'd32768) ? 32768 : longint'(sh_wet);
        mix = (dry * (32768 - m) + g * m) >>> 15;
        if (mix > 8388607) mix = 8388607;
        if (mix < -8388608) mix = -8388608;
        r.audio = mix[23:0];
        return r;
    endfunction

    // Sample driver: hold the offered item until accepted, then advance
    always @(posedge aclk) begin
        automatic bit offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            s_valid <= 1'b1;
        end else begin
            if (s_valid && s_ready) begin
                expected_samples.push_back(process_sample(pending_items[0]));
                pending_items.pop_front();
            end
            offer = (pending_items.size() > 0) && (quiet || $urandom_range(99) >= 9);
            s_valid <= offer;
            if (offer) begin
                s_channel_index <= pending_items[0].ch;
                s_audio_in      <= pending_items[0].audio;
            end
        end
    end

    // Result monitor: compare against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected item: channel %0d audio %0d", m_channel_out, m_audio_out);
                mismatches++;
            end else begin
                if (m_channel_out !== expected_samples[0].ch) begin
                    $error("channel_out: expected %0d, got %0d",
                           expected_samples[0].ch, m_channel_out);
                    mismatches++;
                end
                if (m_audio_out !== expected_samples[0].audio) begin
                    $error("audio_out: expected %0d, got %0d",
                           expected_samples[0].audio, m_audio_out);
                    mismatches++;
                end
                expected_samples.pop_front();
            end
            samples_out++;
        end
    end

    // Receiver readiness, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                m_ready <= 1'b0;
            end else if (!holdoff_done && samples_out >= 900) begin
                holdoff_done <= 1'b1;
                holdoff_left <= 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 9);
            end
        end
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            asc_pkg::REG_BYPASS:      sh_bypass = data[0];
            asc_pkg::REG_COLOR_TYPE:  sh_color  = data[1:0];
            asc_pkg::REG_DRIVE:       sh_drive  = data;
            asc_pkg::REG_TONE:        sh_tone   = data;
            asc_pkg::REG_WET_MIX:     sh_wet    = data;
            asc_pkg::REG_OUTPUT_GAIN: sh_gain   = data;
            default: ;
        endcase
    endtask

    task automatic set_all(logic byp, logic [1:0] color, logic [15:0] drive,
                           logic [15:0] tone, logic [15:0] wet, logic [15:0] gain);
        write_reg(asc_pkg::REG_BYPASS, {15'd0, byp});
        write_reg(asc_pkg::REG_COLOR_TYPE, {14'd0, color});
        write_reg(asc_pkg::REG_DRIVE, drive);
        write_reg(asc_pkg::REG_TONE, tone);
        write_reg(asc_pkg::REG_WET_MIX, wet);
        write_reg(asc_pkg::REG_OUTPUT_GAIN, gain);
    endtask

    task automatic add_item(logic ch, logic signed [23:0] audio);
        sample_t it;
        it.ch = ch;
        it.audio = audio;
        pending_items.push_back(it);
    endtask

    // Let every queued item pass through, then let the pipeline settle
    task automatic drain();
        while (pending_items.size() != 0 || expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random 16-bit value, often one of the edges
    function automatic logic [15:0] edgy16(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        automatic logic signed [23:0] corner [6] = '{
            24'sh7FFFFF, -24'sh800000, 24'sh000000, -24'sh000001, 24'sh000001, 24'sh3A0000
        };
        automatic logic [15:0] tone_v;
        sh_bypass = 1'b0; sh_color = asc_pkg::COLOR_TAPE; sh_drive = 16'd0;
        sh_tone = 16'd0; sh_wet = 16'd32768; sh_gain = 16'd4096;
        dc_avg[0] = 0; dc_avg[1] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults, with field extremes on both channels
        foreach (corner[i]) add_item(i[0], corner[i]);
        drain();

        // Each curve (all but clip at full drive or above); tone extremes; bypass; over-range settings
        set_all(1'b0, asc_pkg::COLOR_TUBE, 16'd32768, 16'h8000, 16'd32768, 16'hFFFF);
        add_item(1'b0, 24'sh7FFFFF); add_item(1'b1, -24'sh800000); add_item(1'b0, 24'sh200000);
        drain();
        set_all(1'b0, asc_pkg::COLOR_XFMR, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'd0);
        add_item(1'b1, 24'sh0C0000); add_item(1'b0, -24'sh160000); add_item(1'b1, 24'sh7FFFFF);
        drain();
        set_all(1'b0, asc_pkg::COLOR_CLIP, 16'd0, 16'd16384, 16'd0, 16'd4096);
        add_item(1'b0, -24'sh800000); add_item(1'b1, 24'sh7FFFFF);
        drain();
        set_all(1'b1, asc_pkg::COLOR_TAPE, 16'd32768, 16'hC000, 16'd16384, 16'd8192);
        add_item(1'b0, 24'sh123456); add_item(1'b1, -24'sh800000);
        drain();
        // Writes to unused indexes must be ignored
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h0000);
        set_all(1'b0, asc_pkg::COLOR_TAPE, 16'd32768, 16'd0, 16'd32768, 16'd4096);
        add_item(1'b0, 24'sh7FFFFF); add_item(1'b1, -24'sh400000); add_item(1'b0, 24'sh0FFFFF);
        drain();

        // Random phases with random settings
        for (int p = 0; p < 16; p++) begin
            tone_v = ($urandom_range(3) == 0) ? edgy16(16'hC000, 16'h4000)
                                             : 16'($signed($urandom_range(32768)) - 16384);
            set_all($urandom_range(6) == 0, 2'($urandom_range(3)),
                    edgy16(16'd0, 16'd32768), tone_v,
                    edgy16(16'd0, 16'd32768), edgy16(16'd0, 16'd4096));
            if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 6)), 16'($urandom));
            for (int n = 0; n < 115; n++) begin
                case ($urandom_range(7))
                    0: add_item(1'($urandom_range(1)),
                                24'($signed($urandom_range(8191)) - 4096));
                    1: add_item(1'($urandom_range(1)),
                                $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000);
                    default: add_item(1'($urandom_range(1)), 24'($urandom));
                endcase
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
